[hw/rtl/i2clcd_pkg.sv]
// Shared types and constants for the I2C expander LCD writer.
package i2clcd_pkg;

  // Beat widths on the stream ports
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_DATA_W  = 7;

  // Request kinds carried in in_tuser[2:0]
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_BYTE   = 3'd1;
  localparam logic [2:0] REQ_NIBBLE = 3'd2;
  localparam logic [2:0] REQ_STOP   = 3'd3;
  localparam logic [2:0] REQ_TICK   = 3'd4;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_BACKLIGHT_ON   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h27;
  localparam logic       BACKLIGHT_ON_RST   = 1'b1;

  // Bus sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_BYTE,
    PH_STOP
  } phase_t;

  // One accepted request
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       reg_select;
    logic       sda_in;
  } item_t;

  // One tick report
  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic nack_seen;
    logic sequence_done;
  } result_t;

endpackage

[hw/rtl/i2clcd_in_stage.sv]
// Input register stage: holds one request beat until the engine takes it.
module i2clcd_in_stage
  import i2clcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] data_byte, [8] sda_in, rest zero
  input  logic [IN_TUSER_W-1:0] in_tuser,   // [2:0] req_type, [3] reg_select
  input  logic                  take,
  output logic                  item_valid,
  output item_t                 item
);

  logic  valid_r;
  item_t item_r;

  // Free when empty or when the held beat leaves this cycle
  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type   <= in_tuser[2:0];
      item_r.reg_select <= in_tuser[3];
      item_r.data_byte  <= in_tdata[7:0];
      item_r.sda_in     <= in_tdata[8];
    end
  end

endmodule

[hw/rtl/i2clcd_engine.sv]
// Bus sequencer: one pin step per tick, request decode and config registers.
module i2clcd_engine
  import i2clcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  item_valid,
  input  item_t                 item,
  input  logic                  res_ready,
  output logic                  take,
  output logic                  res_valid,
  output result_t               res
);

  // Positions inside one data bit (four pin steps)
  localparam logic [1:0] BIT_SET_SDA = 2'd0;
  localparam logic [1:0] BIT_SCL_HI  = 2'd1;
  localparam logic [1:0] BIT_SCL_LO  = 2'd2;
  localparam logic [1:0] BIT_RELEASE = 2'd3;

  // Step numbers
  localparam logic [5:0] ACK_HIGH_STEP   = 6'd32;
  localparam logic [5:0] START_LAST_STEP = 6'd3;
  localparam logic [5:0] STOP_LAST_STEP  = 6'd2;

  // Expander bytes still to go, counted including the one being loaded
  localparam logic [2:0] XB_FULL    = 3'd6;
  localparam logic [2:0] XB_NIBBLE  = 3'd3;
  localparam logic [2:0] XB_EN_HI_A = 3'd5;
  localparam logic [2:0] XB_EN_HI_B = 3'd2;

  // Expander byte: nibble, backlight, enable, R/W low, RS
  function automatic logic [7:0] exp_byte(input logic [7:0] held, input logic rs,
                                          input logic bl, input logic [2:0] r);
    logic [3:0] nib;
    logic       en;
    nib = (r > XB_NIBBLE) ? held[7:4] : held[3:0];
    en  = (r == XB_EN_HI_A) || (r == XB_EN_HI_B);
    return {nib, bl, en, 1'b0, rs};
  endfunction

  phase_t     phase_r, phase_nxt;
  logic [5:0] step_r, step_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] left_r, left_nxt;
  logic [7:0] held_r, held_nxt;
  logic       rs_r, rs_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       nack_r, nack_nxt;
  logic [6:0] addr_r;
  logic       bl_r;
  logic       is_tick;
  logic       done;

  assign take    = item_valid && res_ready;
  assign is_tick = (item.req_type == REQ_TICK);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= DEVICE_ADDRESS_RST;
      bl_r   <= BACKLIGHT_ON_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: addr_r <= cfg_wdata[6:0];
        CFG_BACKLIGHT_ON:   bl_r   <= cfg_wdata[0];
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      step_r  <= '0;
      shift_r <= '0;
      left_r  <= '0;
      held_r  <= '0;
      rs_r    <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      nack_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      held_r  <= held_nxt;
      rs_r    <= rs_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      nack_r  <= nack_nxt;
    end
  end

  // Next state: request decode while idle, one pin step per tick
  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    held_nxt  = held_r;
    rs_nxt    = rs_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    nack_nxt  = nack_r;
    done      = 1'b0;

    if (take) begin
      if (!is_tick) begin
        // Requests only land while idle; anything else is dropped
        if (phase_r == PH_IDLE) begin
          unique case (item.req_type)
            REQ_START: begin
              nack_nxt  = 1'b0;
              phase_nxt = PH_START;
              step_nxt  = '0;
            end
            REQ_BYTE: begin
              held_nxt  = item.data_byte;
              rs_nxt    = item.reg_select;
              shift_nxt = exp_byte(item.data_byte, item.reg_select, bl_r, XB_FULL);
              left_nxt  = XB_FULL - 3'd1;
              phase_nxt = PH_BYTE;
              step_nxt  = '0;
            end
            REQ_NIBBLE: begin
              held_nxt  = {4'h0, item.data_byte[7:4]};
              rs_nxt    = item.reg_select;
              shift_nxt = exp_byte({4'h0, item.data_byte[7:4]}, item.reg_select,
                                   bl_r, XB_NIBBLE);
              left_nxt  = XB_NIBBLE - 3'd1;
              phase_nxt = PH_BYTE;
              step_nxt  = '0;
            end
            REQ_STOP: begin
              phase_nxt = PH_STOP;
              step_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end else begin
        unique case (phase_r)
          PH_START: begin
            unique case (step_r)
              6'd0:    sda_nxt = 1'b1;
              6'd1:    scl_nxt = 1'b1;
              6'd2:    sda_nxt = 1'b0;
              default: scl_nxt = 1'b0;
            endcase
            if (step_r >= START_LAST_STEP) begin
              // Address byte with write bit
              shift_nxt = {addr_r, 1'b0};
              left_nxt  = '0;
              phase_nxt = PH_BYTE;
              step_nxt  = '0;
            end else begin
              step_nxt = step_r + 6'd1;
            end
          end
          PH_BYTE: begin
            if (step_r < ACK_HIGH_STEP) begin
              unique case (step_r[1:0])
                BIT_SET_SDA: sda_nxt = shift_r[7];
                BIT_SCL_HI:  scl_nxt = 1'b1;
                BIT_SCL_LO: begin
                  scl_nxt   = 1'b0;
                  shift_nxt = {shift_r[6:0], 1'b0};
                end
                BIT_RELEASE: sda_nxt = 1'b1;
              endcase
              step_nxt = step_r + 6'd1;
            end else if (step_r == ACK_HIGH_STEP) begin
              // Acknowledge clock high: sample SDA
              scl_nxt  = 1'b1;
              nack_nxt = nack_r | item.sda_in;
              step_nxt = step_r + 6'd1;
            end else begin
              scl_nxt = 1'b0;
              if (left_r != 3'd0) begin
                shift_nxt = exp_byte(held_r, rs_r, bl_r, left_r);
                left_nxt  = left_r - 3'd1;
                phase_nxt = PH_BYTE;
                step_nxt  = '0;
              end else begin
                phase_nxt = PH_IDLE;
                step_nxt  = '0;
                done      = 1'b1;
              end
            end
          end
          PH_STOP: begin
            unique case (step_r)
              6'd0:    sda_nxt = 1'b0;
              6'd1:    scl_nxt = 1'b1;
              default: sda_nxt = 1'b1;
            endcase
            if (step_r >= STOP_LAST_STEP) begin
              phase_nxt = PH_IDLE;
              step_nxt  = '0;
              done      = 1'b1;
            end else begin
              step_nxt = step_r + 6'd1;
            end
          end
          PH_IDLE: begin
            step_nxt = '0;
          end
        endcase
      end
    end
  end

  // Every tick reports the bus after its step
  assign res_valid         = take && is_tick;
  assign res.scl_level     = scl_nxt;
  assign res.sda_level     = sda_nxt;
  assign res.busy_res      = (phase_nxt != PH_IDLE);
  assign res.nack_seen     = nack_nxt;
  assign res.sequence_done = done;

endmodule

[hw/rtl/i2clcd_out_stage.sv]
// Result register: holds one tick report until the sink takes it.
module i2clcd_out_stage
  import i2clcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  result_t                res,
  output logic                   res_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata  // [0] scl_level, [1] sda_level,
                                            // [2] busy_res, [3] nack_seen,
                                            // [4] sequence_done, rest zero
);

  logic    valid_r;
  result_t res_r;

  // Room when empty or when the held beat is taken this cycle
  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, res_r.sequence_done, res_r.nack_seen, res_r.busy_res,
                       res_r.sda_level, res_r.scl_level};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule

[hw/rtl/i2c_expander_lcd_writer_core.sv]
// Top level of the I2C expander LCD writer.
// Bit-banged I2C master that drives a character LCD in 4-bit mode through an
// 8-bit port expander. While idle it takes a start+address, an LCD byte (two
// nibbles), a high nibble alone, or a stop request; each nibble goes out as
// three expander bytes with enable low, high, low. Every tick beat advances
// one pin step while busy and returns one beat with SCL, SDA, busy, sticky
// NACK and done; other beats return nothing. A beat crosses an input
// register, combinational step logic and a result register, so the block
// takes one beat per clock; the only stall is backpressure from the result
// side. Requests that arrive while busy are dropped. Configuration writes
// take effect on the next clock.
module i2c_expander_lcd_writer_core
  import i2clcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,   // 0 device_address, 1 backlight_on
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [7:0] data_byte, [8] sda_in, rest zero
  input  logic [IN_TUSER_W-1:0]  in_tuser,    // [2:0] req_type, [3] reg_select
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata    // [0] scl_level, [1] sda_level,
                                              // [2] busy_res, [3] nack_seen,
                                              // [4] sequence_done, rest zero
);

  logic    take;
  logic    item_valid;
  item_t   item;
  logic    res_ready;
  logic    res_valid;
  result_t res;

  i2clcd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  i2clcd_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  i2clcd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[hw/rtl/i2clcd_checker.sv]
// Port-level checks for the I2C expander LCD writer, bound to the top level.
module i2clcd_checker
  import i2clcd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // The finishing tick never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[2])
    else $error("sequence_done reported with busy set");

  // No result leaves the clock after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  // Unused pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:5] == 3'b000)
    else $error("result pad bits set");

endmodule

bind i2c_expander_lcd_writer_core i2clcd_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
